// ===== design/iaf_pkg.sv =====
// Shared types, codes and character helpers for the integer to ASCII formatter.
`default_nettype none
package iaf_pkg;

  // Stream word widths
  localparam int unsigned IN_TDATA_W  = 72;  // value (64) + action (2), padded to 9 bytes
  localparam int unsigned OUT_TDATA_W = 8;

  // Format selector codes
  localparam logic [1:0] ACT_DEC  = 2'd0;
  localparam logic [1:0] ACT_LHEX = 2'd1;
  localparam logic [1:0] ACT_UHEX = 2'd2;
  localparam logic [1:0] ACT_PTR  = 2'd3;

  // ASCII constants
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_LOW_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_UP_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_X      = 8'h78;  // 'x'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_N      = 8'h6E;  // 'n'
  localparam logic [7:0] CH_I      = 8'h69;  // 'i'
  localparam logic [7:0] CH_L      = 8'h6C;  // 'l'
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'

  // Prefix indexes of the final prefix character
  localparam logic [2:0] NIL_LAST_IDX = 3'd4;
  localparam logic [2:0] HEX_LAST_IDX = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PRE,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic put_pre;
    logic put_dig;
  } cmd_t;

  typedef struct packed {
    logic is_dec;
    logic is_ptr;
    logic neg;
    logic zero;
    logic conv_last;
    logic top_zero;
    logic rem_one;
    logic pre_last;
    logic out_free;
  } status_t;

  // One hex or decimal digit to its character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UP_A : CH_LOW_A;
      if (d < 4'd10) begin
        digit_char = CH_ZERO + {4'd0, d};
      end else begin
        digit_char = base + {4'd0, d} - 8'd10;
      end
    end
  endfunction

  // Prefix text: "-" for negative decimals, "0x" for pointers, "(nil)" for null pointers
  function automatic logic [7:0] prefix_char(input logic [1:0] act, input logic zero,
                                             input logic [2:0] idx);
    logic [7:0] c;
    begin
      c = CH_MINUS;
      if (act == ACT_PTR) begin
        if (zero) begin
          case (idx)
            3'd0:    c = CH_LPAREN;
            3'd1:    c = CH_N;
            3'd2:    c = CH_I;
            3'd3:    c = CH_L;
            default: c = CH_RPAREN;
          endcase
        end else begin
          c = (idx == 3'd0) ? CH_ZERO : CH_X;
        end
      end
      prefix_char = c;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/iaf_ctrl.sv =====
// Sequencing state machine of the integer to ASCII formatter.
`default_nettype none
module iaf_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  iaf_pkg::status_t st,
  output iaf_pkg::cmd_t    cmd
);
  import iaf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SKIP;
          if (st.is_dec) begin
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (st.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (st.top_zero && !st.rem_one) begin
          cmd.skip = 1'b1;
        end else if (st.neg || st.is_ptr) begin
          state_next = ST_PRE;
        end else begin
          state_next = ST_DIGIT;
        end
      end
      ST_PRE: begin
        if (st.out_free) begin
          cmd.put_pre = 1'b1;
          if (st.pre_last) begin
            state_next = (st.is_ptr && st.zero) ? ST_IDLE : ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (st.out_free) begin
          cmd.put_dig = 1'b1;
          if (st.rem_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/iaf_datapath.sv =====
// Digit register, binary to BCD converter and output register of the formatter.
`default_nettype none
module iaf_datapath #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire  [iaf_pkg::IN_TDATA_W-1:0]        s_tdata,
  output logic [iaf_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tlast,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  input  iaf_pkg::cmd_t                         cmd,
  output iaf_pkg::status_t                      st
);
  import iaf_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned NDIG = (W * 30103) / 100000 + 1;  // decimal digits of 2^W-1
  localparam int unsigned HDIG = (W + 3) / 4;
  localparam int unsigned DW   = NDIG * 4;
  localparam int unsigned HW   = HDIG * 4;
  localparam int unsigned RW   = $clog2(NDIG + 1);
  localparam int unsigned CW   = $clog2(W);

  logic [DW-1:0] dig;
  logic [W-1:0]  bin;
  logic [RW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [2:0]    pidx;
  logic [1:0]    act;
  logic          neg;
  logic          zero;

  logic [W-1:0]  in_v;
  logic [1:0]    in_act;
  logic          in_neg;
  logic [W-1:0]  in_mag;
  logic [DW-1:0] dabble;
  logic [DW-1:0] corr;
  logic [3:0]    top;

  assign in_v   = s_tdata[W-1:0];
  assign in_act = s_tdata[65:64];
  assign in_neg = (in_act == ACT_DEC) && in_v[W-1];
  assign in_mag = in_neg ? (~in_v + {{(W-1){1'b0}}, 1'b1}) : in_v;
  assign top    = dig[DW-1 -: 4];

  // Add 3 to every BCD digit of 5 or more, then shift in the next binary bit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      corr[4*i +: 4] = (dig[4*i +: 4] >= 4'd5) ? dig[4*i +: 4] + 4'd3 : dig[4*i +: 4];
    end
    dabble = {corr[DW-2:0], bin[W-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= in_act;
      neg  <= in_neg;
      zero <= (in_v == '0);
      cnt  <= '0;
      pidx <= '0;
      bin  <= in_mag;
      if (in_act == ACT_DEC) begin
        dig <= '0;
        rem <= RW'(NDIG);
      end else begin
        dig <= DW'(in_v) << (DW - HW);
        rem <= RW'(HDIG);
      end
    end
    if (cmd.conv) begin
      dig <= dabble;
      bin <= bin << 1;
      cnt <= cnt + 1'b1;
    end
    if (cmd.skip || cmd.put_dig) begin
      dig <= dig << 4;
      rem <= rem - 1'b1;
    end
    if (cmd.put_pre) begin
      pidx <= pidx + 1'b1;
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.put_pre || cmd.put_dig) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_pre) begin
      m_tdata <= prefix_char(act, zero, pidx);
      m_tlast <= (act == ACT_PTR) && zero && (pidx == NIL_LAST_IDX);
    end else if (cmd.put_dig) begin
      m_tdata <= digit_char(top, act == ACT_UHEX);
      m_tlast <= (rem == RW'(1));
    end
  end

  always_comb begin
    st           = '0;
    st.is_dec    = (in_act == ACT_DEC);
    st.is_ptr    = (act == ACT_PTR);
    st.neg       = neg;
    st.zero      = zero;
    st.conv_last = (cnt == CW'(W - 1));
    st.top_zero  = (top == 4'd0);
    st.rem_one   = (rem == RW'(1));
    st.out_free  = !m_tvalid || m_tready;
    if (act == ACT_PTR) begin
      st.pre_last = zero ? (pidx == NIL_LAST_IDX) : (pidx == HEX_LAST_IDX);
    end else begin
      st.pre_last = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: controller plus datapath.
//
// Usage:
//   Input stream (s_*): one word per value. s_tdata[63:0] is the value (only
//   the low VALUE_WIDTH bits count), s_tdata[65:64] the format: 0 signed
//   decimal, 1 lowercase hex, 2 uppercase hex, 3 pointer ("0x..." or "(nil)").
//   Output stream (m_*): one ASCII character per word, most significant
//   first; m_tlast marks the final character of a value's text.
//   One value is worked on at a time; s_tready is high only while idle.
//   Steps per value: the load, in decimal then the shift-and-add-3 BCD
//   converter over all VALUE_WIDTH bits, then the drop of each leading zero
//   digit, the exit from the zero-drop phase and finally the characters.
//   The converter takes one bit per cycle; the output register sends one
//   character per cycle while m_tready does not stall it.
//   Reset (rst, synchronous) returns to idle and empties the output register.
//   A stall on m_tready holds the current character in the output register
//   and pauses the sequencer; nothing is lost or repeated.
`default_nettype none
module integer_to_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [iaf_pkg::IN_TDATA_W-1:0]     s_tdata,   // [63:0] value, [65:64] action
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [iaf_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [7:0] text_char
  output logic                               m_tlast    // last_char
);
  import iaf_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer: decides when to load, convert, skip zeros and emit
  iaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Digit storage, BCD conversion and the output register
  iaf_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire
